/* rtl/core/icl_pkg.sv */
// icl_pkg: shared types and codes of the inode cache with its lru free list
// holds the request and result beat structs, status codes and the default slot count
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package icl_pkg;

  // default number of in-core inode slots
  localparam int unsigned SlotsDefault = 64;

  // field widths of the request and result beats
  localparam int unsigned DevW  = 8;
  localparam int unsigned NumW  = 16;
  localparam int unsigned SlotW = 6;
  localparam int unsigned StatW = 3;
  localparam int unsigned RefW  = 8;
  localparam int unsigned TagW  = DevW + NumW;

  // request kinds
  localparam logic KindGet = 1'b0;
  localparam logic KindPut = 1'b1;

  // result status codes
  localparam logic [StatW-1:0] StHit      = 3'd0;
  localparam logic [StatW-1:0] StFill     = 3'd1;
  localparam logic [StatW-1:0] StNoFree   = 3'd2;
  localparam logic [StatW-1:0] StReleased = 3'd3;
  localparam logic [StatW-1:0] StHeld     = 3'd4;

  // one request beat
  typedef struct packed {
    logic            kind;
    logic [DevW-1:0] device;
    logic [NumW-1:0] inode_number;
    logic [SlotW-1:0] slot;
  } icl_req_t;

  // one result beat
  typedef struct packed {
    logic [SlotW-1:0] slot_out;
    logic [StatW-1:0] status;
    logic [RefW-1:0]  ref_count;
  } icl_res_t;

  // status of the tag scan unit toward the sequencer
  typedef struct packed {
    logic done;
    logic hit;
  } icl_scan_t;

endpackage

`default_nettype wire

/* rtl/core/icl_ram.sv */
// icl_ram: generic simple dual port ram, one write and one read port, registered read
// used for the slot tag, reference count and free list link stores
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module icl_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

/* rtl/core/icl_tag_scan.sv */
// icl_tag_scan: walks the slot tag ram one address a cycle with one shared comparator
// stops at the lowest matching slot or after the last slot; depends on icl_pkg
`timescale 1ns / 1ps
`default_nettype none

module icl_tag_scan
  import icl_pkg::*;
#(
  parameter int unsigned Slots = SlotsDefault,
  localparam int unsigned SW = $clog2(Slots)
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            go_i,
  input  wire logic [TagW-1:0] key_i,
  input  wire logic [TagW-1:0] tag_rdata_i,
  output logic      [SW-1:0]   tag_raddr_o,
  output icl_scan_t            scan_o,
  output logic      [SW-1:0]   idx_o
);

  localparam logic [SW-1:0] LastIdx = SW'(Slots - 1);

  logic          iss_q;
  logic [SW-1:0] addr_q;
  logic          cmp_vld_q;
  logic [SW-1:0] cmp_idx_q;
  logic          match;
  logic          done;

  // compare the tag read last cycle against the key
  assign match = cmp_vld_q && (tag_rdata_i == key_i);
  assign done  = cmp_vld_q && (match || (cmp_idx_q == LastIdx));

  // issue side: one tag address a cycle until a match or the last slot
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      iss_q     <= 1'b0;
      addr_q    <= '0;
      cmp_vld_q <= 1'b0;
      cmp_idx_q <= '0;
    end else if (go_i) begin
      iss_q     <= 1'b1;
      addr_q    <= '0;
      cmp_vld_q <= 1'b0;
    end else begin
      cmp_vld_q <= iss_q && !done;
      cmp_idx_q <= addr_q;
      if (iss_q) begin
        if (done || (addr_q == LastIdx)) begin
          iss_q <= 1'b0;
        end else begin
          addr_q <= addr_q + SW'(1);
        end
      end
    end
  end

  assign tag_raddr_o = addr_q;
  assign scan_o.done = done;
  assign scan_o.hit  = match;
  assign idx_o       = cmp_idx_q;

endmodule

`default_nettype wire

/* rtl/core/inode_cache_lru_free_list_core.sv */
// inode cache with lru free list: get looks a tag up by a serial scan, put releases a slot
// get: tag scan at one slot a cycle through the tag ram port, then count and list update;
// put: count read and decrement, then append to the free list tail at zero; one
// request at a time, busy_o high while a request runs
// reset: a clearing pass writes the tag, count and link rams; busy_o stays
// high meanwhile; each result is a one cycle strobe and the receiver cannot stall
`timescale 1ns / 1ps
`default_nettype none

module inode_cache_lru_free_list_core
  import icl_pkg::*;
#(
  parameter int unsigned Slots = SlotsDefault
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     start_i,
  input  wire icl_req_t req_i,
  output logic          busy_o,
  output logic          result_valid_o,
  output icl_res_t      result_o
);

  localparam int unsigned SW = $clog2(Slots);
  localparam int unsigned CW = $clog2(Slots + 1);
  localparam logic [SW-1:0] LastIdx = SW'(Slots - 1);

  // sequencer state codes
  localparam logic [3:0] SInit   = 4'd0;
  localparam logic [3:0] SIdle   = 4'd1;
  localparam logic [3:0] SScan   = 4'd2;
  localparam logic [3:0] SHitRd  = 4'd3;
  localparam logic [3:0] SHitEv  = 4'd4;
  localparam logic [3:0] SUnlRd  = 4'd5;
  localparam logic [3:0] SUnlWr  = 4'd6;
  localparam logic [3:0] SFin    = 4'd7;
  localparam logic [3:0] SPutRd  = 4'd8;
  localparam logic [3:0] SPutEv  = 4'd9;
  localparam logic [3:0] SAppA   = 4'd10;
  localparam logic [3:0] SAppB   = 4'd11;

  logic [3:0]    state_q, state_d;
  icl_req_t      req_q, req_d;
  logic [SW-1:0] tgt_q, tgt_d;
  logic [RefW-1:0] cnt_q, cnt_d;
  logic          fill_q, fill_d;
  logic [SW-1:0] init_q, init_d;
  logic [SW-1:0] head_q, head_d;
  logic [SW-1:0] tail_q, tail_d;
  logic [CW-1:0] count_q, count_d;
  icl_res_t      res_q, res_d;
  logic          res_vld_q, res_vld_d;

  // ram ports
  logic            tag_we;
  logic [SW-1:0]   tag_waddr, tag_raddr;
  logic [TagW-1:0] tag_wdata, tag_rdata;
  logic            refs_we;
  logic [SW-1:0]   refs_waddr, refs_raddr;
  logic [RefW-1:0] refs_wdata, refs_rdata;
  logic            nxt_we;
  logic [SW-1:0]   nxt_waddr, nxt_raddr, nxt_wdata, nxt_rdata;
  logic            prv_we;
  logic [SW-1:0]   prv_waddr, prv_raddr, prv_wdata, prv_rdata;

  icl_scan_t     scan;
  logic [SW-1:0] scan_idx;
  logic          scan_go;
  logic [SW-1:0] put_idx;
  logic          put_in_range;

  assign put_idx      = SW'(req_q.slot);
  assign put_in_range = 32'(req_q.slot) < Slots;

  // storage
  icl_ram #(.Width(TagW), .Depth(Slots)) u_tag_ram (
    .clk_i(clk_i), .we_i(tag_we), .waddr_i(tag_waddr), .wdata_i(tag_wdata),
    .raddr_i(tag_raddr), .rdata_o(tag_rdata)
  );

  icl_ram #(.Width(RefW), .Depth(Slots)) u_refs_ram (
    .clk_i(clk_i), .we_i(refs_we), .waddr_i(refs_waddr), .wdata_i(refs_wdata),
    .raddr_i(refs_raddr), .rdata_o(refs_rdata)
  );

  icl_ram #(.Width(SW), .Depth(Slots)) u_next_ram (
    .clk_i(clk_i), .we_i(nxt_we), .waddr_i(nxt_waddr), .wdata_i(nxt_wdata),
    .raddr_i(nxt_raddr), .rdata_o(nxt_rdata)
  );

  icl_ram #(.Width(SW), .Depth(Slots)) u_prev_ram (
    .clk_i(clk_i), .we_i(prv_we), .waddr_i(prv_waddr), .wdata_i(prv_wdata),
    .raddr_i(prv_raddr), .rdata_o(prv_rdata)
  );

  // serial tag lookup
  icl_tag_scan #(.Slots(Slots)) u_tag_scan (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .go_i        (scan_go),
    .key_i       ({req_q.device, req_q.inode_number}),
    .tag_rdata_i (tag_rdata),
    .tag_raddr_o (tag_raddr),
    .scan_o      (scan),
    .idx_o       (scan_idx)
  );

  // sequencer
  always_comb begin
    state_d   = state_q;
    req_d     = req_q;
    tgt_d     = tgt_q;
    cnt_d     = cnt_q;
    fill_d    = fill_q;
    init_d    = init_q;
    head_d    = head_q;
    tail_d    = tail_q;
    count_d   = count_q;
    res_d     = res_q;
    res_vld_d = 1'b0;
    scan_go   = 1'b0;

    tag_we     = 1'b0;
    tag_waddr  = tgt_q;
    tag_wdata  = {req_q.device, req_q.inode_number};
    refs_we    = 1'b0;
    refs_waddr = tgt_q;
    refs_wdata = cnt_q;
    refs_raddr = tgt_q;
    nxt_we     = 1'b0;
    nxt_waddr  = tgt_q;
    nxt_wdata  = tgt_q;
    nxt_raddr  = tgt_q;
    prv_we     = 1'b0;
    prv_waddr  = tgt_q;
    prv_wdata  = tgt_q;
    prv_raddr  = tgt_q;

    case (state_q)
      // clearing pass: every slot free, in index order
      SInit: begin
        tag_we     = 1'b1;
        tag_waddr  = init_q;
        tag_wdata  = {DevW'(0), NumW'(init_q)};
        refs_we    = 1'b1;
        refs_waddr = init_q;
        refs_wdata = '0;
        nxt_we     = 1'b1;
        nxt_waddr  = init_q;
        nxt_wdata  = (init_q == LastIdx) ? '0 : init_q + SW'(1);
        prv_we     = 1'b1;
        prv_waddr  = init_q;
        prv_wdata  = (init_q == '0) ? LastIdx : init_q - SW'(1);
        if (init_q == LastIdx) begin
          state_d = SIdle;
        end else begin
          init_d = init_q + SW'(1);
        end
      end

      SIdle: begin
        if (start_i) begin
          req_d = req_i;
          if (req_i.kind == KindGet) begin
            scan_go = 1'b1;
            state_d = SScan;
          end else begin
            state_d = SPutRd;
          end
        end
      end

      SScan: begin
        if (scan.done) begin
          if (scan.hit) begin
            tgt_d   = scan_idx;
            state_d = SHitRd;
          end else if (count_q == '0) begin
            res_vld_d       = 1'b1;
            res_d.slot_out  = '0;
            res_d.status    = StNoFree;
            res_d.ref_count = '0;
            state_d         = SIdle;
          end else begin
            tgt_d   = head_q;
            fill_d  = 1'b1;
            cnt_d   = RefW'(1);
            state_d = SUnlRd;
          end
        end
      end

      SHitRd: begin
        state_d = SHitEv;
      end

      // saturating increment; a slot at zero leaves the free list
      SHitEv: begin
        cnt_d      = (refs_rdata == '1) ? refs_rdata : refs_rdata + RefW'(1);
        refs_we    = 1'b1;
        refs_wdata = cnt_d;
        fill_d     = 1'b0;
        state_d    = (refs_rdata == '0) ? SUnlRd : SFin;
      end

      // unlink: short lists collapse, else fetch both links
      SUnlRd: begin
        if (count_q == '0) begin
          state_d = SFin;
        end else if (count_q == CW'(1)) begin
          count_d = '0;
          head_d  = '0;
          tail_d  = '0;
          state_d = SFin;
        end else begin
          state_d = SUnlWr;
        end
      end

      SUnlWr: begin
        nxt_we    = 1'b1;
        nxt_waddr = prv_rdata;
        nxt_wdata = nxt_rdata;
        prv_we    = 1'b1;
        prv_waddr = nxt_rdata;
        prv_wdata = prv_rdata;
        if (tgt_q == head_q) begin
          head_d = nxt_rdata;
        end
        if (tgt_q == tail_q) begin
          tail_d = prv_rdata;
        end
        count_d = count_q - CW'(1);
        state_d = SFin;
      end

      // result of a get; a fill also retags the slot
      SFin: begin
        if (fill_q) begin
          tag_we     = 1'b1;
          refs_we    = 1'b1;
          refs_wdata = RefW'(1);
        end
        res_vld_d       = 1'b1;
        res_d.slot_out  = SlotW'(tgt_q);
        res_d.status    = fill_q ? StFill : StHit;
        res_d.ref_count = cnt_q;
        state_d         = SIdle;
      end

      SPutRd: begin
        refs_raddr = put_idx;
        tgt_d      = put_idx;
        state_d    = SPutEv;
      end

      // decrement a nonzero count of a slot in range; at zero the slot is appended to the free list tail
      SPutEv: begin
        res_d.slot_out = req_q.slot;
        if (!put_in_range || (refs_rdata == '0)) begin
          res_vld_d       = 1'b1;
          res_d.status    = StReleased;
          res_d.ref_count = '0;
          state_d         = SIdle;
        end else begin
          cnt_d      = refs_rdata - RefW'(1);
          refs_we    = 1'b1;
          refs_wdata = cnt_d;
          if (cnt_d != '0) begin
            res_vld_d       = 1'b1;
            res_d.status    = StHeld;
            res_d.ref_count = cnt_d;
            state_d         = SIdle;
          end else begin
            state_d = SAppA;
          end
        end
      end

      SAppA: begin
        if (count_q == '0) begin
          nxt_we          = 1'b1;
          prv_we          = 1'b1;
          head_d          = tgt_q;
          tail_d          = tgt_q;
          count_d         = CW'(1);
          res_vld_d       = 1'b1;
          res_d.status    = StReleased;
          res_d.ref_count = '0;
          state_d         = SIdle;
        end else begin
          nxt_we    = 1'b1;
          nxt_waddr = tail_q;
          prv_we    = 1'b1;
          prv_wdata = tail_q;
          state_d   = SAppB;
        end
      end

      SAppB: begin
        nxt_we          = 1'b1;
        nxt_wdata       = head_q;
        prv_we          = 1'b1;
        prv_waddr       = head_q;
        tail_d          = tgt_q;
        count_d         = count_q + CW'(1);
        res_vld_d       = 1'b1;
        res_d.status    = StReleased;
        res_d.ref_count = '0;
        state_d         = SIdle;
      end

      default: begin
        state_d = SIdle;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= SInit;
      init_q    <= '0;
      head_q    <= '0;
      tail_q    <= LastIdx;
      count_q   <= CW'(Slots);
      fill_q    <= 1'b0;
      res_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      init_q    <= init_d;
      head_q    <= head_d;
      tail_q    <= tail_d;
      count_q   <= count_d;
      fill_q    <= fill_d;
      res_vld_q <= res_vld_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    req_q <= req_d;
    tgt_q <= tgt_d;
    cnt_q <= cnt_d;
    res_q <= res_d;
  end

  assign busy_o         = (state_q != SIdle);
  assign result_valid_o = res_vld_q;
  assign result_o       = res_q;

endmodule

`default_nettype wire

/* rtl/core/icl_checker.sv */
// icl_checker: port level checks of the inode cache core over time
// depends on icl_pkg; bound to inode_cache_lru_free_list_core below
`timescale 1ns / 1ps
`default_nettype none

module icl_checker
  import icl_pkg::*;
(
  input wire logic     clk_i,
  input wire logic     rst_ni,
  input wire logic     start_i,
  input wire logic     busy_i,
  input wire logic     result_valid_i,
  input wire icl_res_t result_i
);

  // busy is high in the cycle after an accepted beat
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_i) |=> busy_i)
    else $error("busy low right after an accepted beat");

  // a result always ends a busy phase
  a_result_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_i |-> $past(busy_i))
    else $error("result without a preceding busy phase");

  // results never come in consecutive cycles
  a_single_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_i |=> !result_valid_i)
    else $error("result strobe longer than one cycle");

  // no free slot returns a zero slot and count
  a_nofree_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_i && (result_i.status == StNoFree)) |->
      ((result_i.slot_out == '0) && (result_i.ref_count == '0)))
    else $error("no free result with nonzero fields");

  // a fill starts at one reference, a held slot keeps a nonzero count
  a_count_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_i |->
      (((result_i.status == StFill) && (result_i.ref_count == RefW'(1))) ||
       ((result_i.status == StHeld) && (result_i.ref_count != '0)) ||
       (result_i.status == StHit) || (result_i.status == StNoFree) ||
       ((result_i.status == StReleased) && (result_i.ref_count == '0))))
    else $error("status and reference count disagree");

endmodule

bind inode_cache_lru_free_list_core icl_checker u_icl_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start_i        (start_i),
  .busy_i         (busy_o),
  .result_valid_i (result_valid_o),
  .result_i       (result_o)
);

`default_nettype wire

/* test/inode_cache_lru_free_list_core_test.sv */
// testbench for the inode cache core: directed and random get and put beats checked against
// an in-bench model of slot tags, reference counts and the release-order free list
// depends on icl_pkg and inode_cache_lru_free_list_core
`timescale 1ns / 1ps

module inode_cache_lru_free_list_core_test;
  import icl_pkg::*;

  localparam int unsigned NSlots = SlotsDefault;
  localparam int ItemsRandom = 1450;
  localparam int QuietLimit = 1000;
  localparam int DrainCycles = NSlots + 16;
  localparam int PoolSize = 40;

  logic     clk_i   = 1'b0;
  logic     rst_ni  = 1'b1;
  logic     start_i = 1'b0;
  icl_req_t req_i   = '0;
  logic     busy_o;
  logic     result_valid_o;
  icl_res_t result_o;

  // model of the cache: slot tags, counts and the circular free list
  logic [DevW-1:0]  line_dev  [NSlots];
  logic [NumW-1:0]  line_num  [NSlots];
  logic [RefW-1:0]  line_refs [NSlots];
  logic [SlotW-1:0] lru_next  [NSlots];
  logic [SlotW-1:0] lru_prev  [NSlots];
  logic [SlotW-1:0] lru_head;
  logic [SlotW-1:0] lru_tail;
  int               lru_free;

  icl_req_t requests_q[$];
  icl_res_t results_due_q[$];
  icl_res_t result_want;

  logic [TagW-1:0] tag_pool [PoolSize];
  int idle_pct = 0;
  int n_queued = 0;
  int n_accepted = 0;
  int n_errors = 0;
  int n_saturated = 0;
  int n_status [5] = '{default: 0};
  int quiet_cycles;

  inode_cache_lru_free_list_core #(
    .Slots (NSlots)
  ) u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .req_i          (req_i),
    .busy_o         (busy_o),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // take a slot off the free list, wherever it sits
  function automatic void lru_unlink(int s);
    logic [SlotW-1:0] n;
    logic [SlotW-1:0] p;
    if (lru_free == 0) return;
    if (lru_free == 1) begin
      lru_free = 0;
      lru_head = '0;
      lru_tail = '0;
      return;
    end
    n = lru_next[s];
    p = lru_prev[s];
    lru_next[p] = n;
    lru_prev[n] = p;
    if (s == int'(lru_head)) lru_head = n;
    if (s == int'(lru_tail)) lru_tail = p;
    lru_free--;
  endfunction

  // result of one get or put beat, updating the model state
  function automatic icl_res_t cache_access_result(icl_req_t r);
    icl_res_t res;
    int hit;
    int v;
    res.slot_out  = '0;
    res.status    = StNoFree;
    res.ref_count = '0;
    hit = -1;
    if (r.kind == KindGet) begin
      // lowest matching slot wins
      for (int i = NSlots - 1; i >= 0; i--) begin
        if (line_dev[i] == r.device && line_num[i] == r.inode_number) hit = i;
      end
      if (hit >= 0) begin
        if (line_refs[hit] == '0) lru_unlink(hit);
        if (line_refs[hit] != '1) line_refs[hit]++;
        res.slot_out  = hit[SlotW-1:0];
        res.status    = StHit;
        res.ref_count = line_refs[hit];
      end else if (lru_free != 0) begin
        v = int'(lru_head);
        lru_unlink(v);
        line_dev[v]   = r.device;
        line_num[v]   = r.inode_number;
        line_refs[v]  = RefW'(1);
        res.slot_out  = v[SlotW-1:0];
        res.status    = StFill;
        res.ref_count = RefW'(1);
      end
    end else begin
      res.slot_out = r.slot;
      res.status   = StReleased;
      if (32'(r.slot) < NSlots && line_refs[r.slot] != '0) begin
        line_refs[r.slot]--;
        res.ref_count = line_refs[r.slot];
        if (line_refs[r.slot] != '0) begin
          res.status = StHeld;
        end else if (lru_free == 0) begin
          // list was empty: slot becomes a list of one
          lru_head = r.slot;
          lru_tail = r.slot;
          lru_next[r.slot] = r.slot;
          lru_prev[r.slot] = r.slot;
          lru_free++;
        end else begin
          lru_next[lru_tail] = r.slot;
          lru_prev[r.slot]   = lru_tail;
          lru_next[r.slot]   = lru_head;
          lru_prev[lru_head] = r.slot;
          lru_tail = r.slot;
          lru_free++;
        end
      end
    end
    return res;
  endfunction

  // beat builders; unused fields carry random bits
  function automatic icl_req_t get_req(logic [TagW-1:0] tag);
    icl_req_t r;
    r.kind         = KindGet;
    r.device       = tag[TagW-1:NumW];
    r.inode_number = tag[NumW-1:0];
    r.slot         = SlotW'($urandom);
    return r;
  endfunction

  function automatic icl_req_t put_req(logic [SlotW-1:0] s);
    icl_req_t r;
    r.kind         = KindPut;
    r.device       = DevW'($urandom);
    r.inode_number = NumW'($urandom);
    r.slot         = s;
    return r;
  endfunction

  // random slot with a nonzero count, or -1
  function automatic int held_slot();
    int picks[$];
    for (int i = 0; i < NSlots; i++) begin
      if (line_refs[i] != '0) picks.push_back(i);
    end
    if (picks.size() == 0) return -1;
    return picks[$urandom_range(picks.size() - 1)];
  endfunction

  task automatic queue_request(icl_req_t r);
    while (requests_q.size() >= 2) @(negedge clk_i);
    requests_q.push_back(r);
    n_queued++;
  endtask

  task automatic wait_quiet();
    while (requests_q.size() != 0 || results_due_q.size() != 0) @(negedge clk_i);
  endtask

  // driver: present the oldest queued request until it is accepted, idle at random
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_i <= 1'b0;
      req_i   <= '0;
    end else begin
      if (start_i && !busy_o) begin
        results_due_q.push_back(cache_access_result(req_i));
        void'(requests_q.pop_front());
        n_accepted++;
      end
      if (requests_q.size() != 0 && int'($urandom_range(99)) >= idle_pct) begin
        start_i <= 1'b1;
        req_i   <= requests_q[0];
      end else begin
        start_i <= 1'b0;
      end
    end
  end

  // monitor: compare each result beat with the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) begin
      if (results_due_q.size() == 0) begin
        $error("result beat with nothing expected: slot_out %0d status %0d ref_count %0d",
               result_o.slot_out, result_o.status, result_o.ref_count);
        n_errors++;
      end else begin
        result_want = results_due_q.pop_front();
        n_status[result_want.status]++;
        if (result_want.status == StHit && result_want.ref_count == '1) n_saturated++;
        if (result_o.slot_out !== result_want.slot_out) begin
          $error("slot_out: expected %0d, got %0d", result_want.slot_out, result_o.slot_out);
          n_errors++;
        end
        if (result_o.status !== result_want.status) begin
          $error("status: expected %0d, got %0d", result_want.status, result_o.status);
          n_errors++;
        end
        if (result_o.ref_count !== result_want.ref_count) begin
          $error("ref_count: expected %0d, got %0d", result_want.ref_count, result_o.ref_count);
          n_errors++;
        end
      end
    end
  end

  // watchdog on cycles with neither an accepted request nor a result
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quiet_cycles <= 0;
    end else if ((start_i && !busy_o) || result_valid_o) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("watchdog: no progress for %0d cycles", QuietLimit);
      $display("Test completed with failures");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // stimulus
  initial begin
    int item_target;
    int ep;
    int k;
    int sat_slot;
    int idle_plan [3];
    bit sat_done;
    logic [TagW-1:0] t;

    idle_plan = '{0, 49, 9};
    sat_done = 1'b0;

    // model reset: every slot free, in index order
    for (int i = 0; i < NSlots; i++) begin
      line_dev[i]  = '0;
      line_num[i]  = NumW'(i);
      line_refs[i] = '0;
      lru_next[i]  = SlotW'((i + 1) % NSlots);
      lru_prev[i]  = SlotW'((i + NSlots - 1) % NSlots);
    end
    lru_head = '0;
    lru_tail = SlotW'(NSlots - 1);
    lru_free = int'(NSlots);

    // pool of recurring tags, some matching the reset tags
    for (int i = 0; i < PoolSize; i++) begin
      if (i < 8) tag_pool[i] = {8'd0, 16'(i * 7)};
      else tag_pool[i] = {8'($urandom), 16'($urandom)};
    end
    tag_pool[8] = {8'hFF, 16'hFFFF};
    tag_pool[9] = {8'h00, 16'hFFFF};

    rst_ni = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: reset tags, field extremes, list head, middle and tail, ignored puts
    queue_request(get_req({8'd0, 16'd5}));         // hit on a free slot mid-list
    queue_request(get_req({8'd0, 16'd0}));         // hit on the list head
    queue_request(get_req({8'd0, 16'd63}));        // hit on the list tail
    queue_request(get_req({8'hFF, 16'hFFFF}));     // miss, fills the oldest free slot
    queue_request(get_req({8'hFF, 16'hFFFF}));     // hit, count two
    queue_request(put_req(6'd1));                  // still referenced
    queue_request(put_req(6'd1));                  // released to the tail
    queue_request(put_req(6'd1));                  // put on zero count, ignored
    queue_request(put_req(6'd63));                 // released
    queue_request(get_req({8'd0, 16'd63}));        // hit on the tail after release
    queue_request(get_req({8'h5A, 16'hA5A5}));
    queue_request(put_req(6'd40));                 // never referenced, ignored
    queue_request(get_req({8'd1, 16'd40}));        // same number, other device: miss
    queue_request(get_req({8'd0, 16'h8000}));
    queue_request(put_req(6'd0));
    queue_request(put_req(6'd5));
    queue_request(put_req(6'd63));
    wait_quiet();

    // random episodes
    item_target = n_queued + ItemsRandom;
    while (n_queued < item_target) begin
      idle_pct = idle_plan[(n_queued / 150) % 3];
      ep = int'($urandom_range(99));
      if (!sat_done && n_queued > item_target - 900) begin
        // count saturation: make room, hammer one tag, then release it fully
        wait_quiet();
        while (lru_free == 0) begin
          k = held_slot();
          queue_request(put_req(k[SlotW-1:0]));
          wait_quiet();
        end
        t = TagW'($urandom);
        repeat (258) queue_request(get_req(t));
        wait_quiet();
        sat_slot = 0;
        for (int i = NSlots - 1; i >= 0; i--) begin
          if ({line_dev[i], line_num[i]} == t) sat_slot = i;
        end
        repeat (256) queue_request(put_req(sat_slot[SlotW-1:0]));
        sat_done = 1'b1;
      end else if (ep < 55) begin
        // mixed traffic on recurring tags
        repeat (40) begin
          if ($urandom_range(99) < 55) begin
            if ($urandom_range(99) < 85) t = tag_pool[$urandom_range(PoolSize - 1)];
            else t = TagW'($urandom);
            queue_request(get_req(t));
          end else begin
            k = held_slot();
            if (k < 0 || $urandom_range(99) < 10) k = int'($urandom_range(NSlots - 1));
            queue_request(put_req(k[SlotW-1:0]));
          end
        end
      end else if (ep < 70) begin
        // fresh tags until the free list runs dry and past it
        k = lru_free + int'($urandom_range(1, 4));
        repeat (k) begin
          t = TagW'($urandom);
          queue_request(get_req(t));
        end
      end else begin
        // one put on every referenced slot, plus stray puts
        for (int i = 0; i < NSlots; i++) begin
          if (line_refs[i] != '0) queue_request(put_req(i[SlotW-1:0]));
        end
        repeat (2) queue_request(put_req(SlotW'($urandom)));
      end
    end

    wait_quiet();
    repeat (DrainCycles) @(posedge clk_i);

    $display("ran %0d requests: %0d hits (%0d at saturation), %0d fills, %0d with no free slot",
             n_accepted, n_status[StHit], n_saturated, n_status[StFill], n_status[StNoFree]);
    $display("puts: %0d released, %0d still referenced; %0d field mismatches",
             n_status[StReleased], n_status[StHeld], n_errors);
    if (n_errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
